// ===== rtl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// shared types and constants of the generational handle table
// ----------------------------------------------------------------------------
package ght_pkg;

  // fixed field widths of the transaction payloads
  localparam int IDX_W   = 10;
  localparam int GEN_W   = 16;
  localparam int COMP_W  = 3;
  localparam int WORD_W  = 32;
  localparam int LIMIT_W = 11;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_ENTITY_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // generation value of a slot after reset
  localparam logic [GEN_W-1:0] GEN_RESET = 16'd1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_FREE   = 2'd1,
    OP_SET    = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_STALE = 2'd2
  } sts_t;

  // one slot of the slot memory
  typedef struct packed {
    logic             occ;
    logic [GEN_W-1:0] gen;
  } slot_entry_t;

endpackage

// ===== rtl/ght_slot_store.sv =====
// ----------------------------------------------------------------------------
// ght_slot_store
// slot memory: occupied bit and generation counter per slot
// ----------------------------------------------------------------------------
module ght_slot_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  ght_pkg::slot_entry_t  wentry,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output ght_pkg::slot_entry_t  rentry
);
  import ght_pkg::*;

  slot_entry_t mem_r [DEPTH];
  slot_entry_t rentry_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wentry;
    end
    if (re) begin
      rentry_r <= mem_r[raddr];
    end
  end

  assign rentry = rentry_r;

endmodule

// ===== rtl/ght_comp_store.sv =====
// ----------------------------------------------------------------------------
// ght_comp_store
// component word memory, one row of component words per slot
// ----------------------------------------------------------------------------
module ght_comp_store #(
  parameter int SLOTS = 1024,
  parameter int TYPES = 8,
  parameter int SW    = $clog2(SLOTS),
  parameter int CW    = (TYPES > 1) ? $clog2(TYPES) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [SW-1:0]              slot,
  input  logic [CW-1:0]              comp,
  input  logic [ght_pkg::WORD_W-1:0] wdata,
  output logic [ght_pkg::WORD_W-1:0] rdata
);
  import ght_pkg::*;

  localparam int DEPTH = SLOTS * TYPES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic [31:0]       addr_full;
  logic [AW-1:0]     addr;

  // row base plus word within the row
  assign addr_full = 32'(slot) * 32'(TYPES) + 32'(comp);
  assign addr      = addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/generational_handle_table.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table
// handle allocator with per-slot generation counters and component words
// ----------------------------------------------------------------------------
// Handles are a slot index plus a 16-bit generation. The tuser of an input
// transaction selects create, free, set or get; every input transaction gives
// exactly one result transaction with a status in out_tuser. One transaction
// is worked on at a time. A successful create scans from the free pointer to
// a free slot, takes it, and then scans from the slot after it to the next
// free slot. The free-slot scan reads the slot memory one slot per cycle
// through its single read port; the component row clear writes one word per
// cycle and runs alongside the second scan. After reset a clearing pass sets
// every generation to 1 and every slot unoccupied; no input transaction is
// accepted during it, configuration writes are.
// ----------------------------------------------------------------------------
module generational_handle_table #(
  parameter int MAX_SLOTS       = 1024,
  parameter int COMPONENT_TYPES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [9:0] slot_index, [25:10] slot_generation, [28:26] component_slot,
  // [60:29] component_word, [63:61] zero
  input  logic [63:0]                    in_tdata,
  // [1:0] op
  input  logic [1:0]                     in_tuser,
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [9:0] new_index, [25:10] new_generation, [57:26] read_word, [63:58] zero
  output logic [63:0]                    out_tdata,
  // [1:0] status
  output logic [1:0]                     out_tuser,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ght_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ght_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ght_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import ght_pkg::*;

  localparam int IW  = $clog2(MAX_SLOTS);
  localparam int LW  = IW + 1;
  localparam int CIW = (COMPONENT_TYPES > 1) ? $clog2(COMPONENT_TYPES) : 1;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,  // clearing pass over the slot memory
    S_IDLE = 9'b000000010,  // ready for the next transaction
    S_RD   = 9'b000000100,  // slot memory read issued
    S_SCAN = 9'b000001000,  // free-slot scan, one slot per cycle
    S_TAKE = 9'b000010000,  // mark the found slot occupied
    S_FIN  = 9'b000100000,  // wait for the component row clear
    S_CHK  = 9'b001000000,  // handle check for free, set and get
    S_GETW = 9'b010000000,  // component word read in flight
    S_RESP = 9'b100000000   // hand the result to the output register
  } state_t;

  // control state
  state_t               state_r, state_nxt;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [IW-1:0]        fp_r, fp_nxt;
  logic [LW-1:0]        live_r, live_nxt;
  logic [IW-1:0]        init_cnt_r, init_cnt_nxt;
  logic                 ph_r, ph_nxt;
  logic                 cclr_busy_r, cclr_busy_nxt;
  logic [CIW-1:0]       cclr_cnt_r, cclr_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // transaction payload
  op_t                  op_r, op_nxt;
  logic                 idx_ok_r, idx_ok_nxt;
  logic [GEN_W-1:0]     gen_r, gen_nxt;
  logic [COMP_W-1:0]    comp_r, comp_nxt;
  logic [WORD_W-1:0]    word_r, word_nxt;
  logic [IW-1:0]        sp_r, sp_nxt;       // slot being read
  logic [LW-1:0]        cnt_r, cnt_nxt;     // slots left to scan
  logic [IW-1:0]        slot_r, slot_nxt;   // slot taken by create
  sts_t                 res_sts_r, res_sts_nxt;
  logic [IDX_W-1:0]     res_idx_r, res_idx_nxt;
  logic [GEN_W-1:0]     res_gen_r, res_gen_nxt;
  logic [WORD_W-1:0]    res_word_r, res_word_nxt;
  sts_t                 out_sts_r, out_sts_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [GEN_W-1:0]     out_gen_r, out_gen_nxt;
  logic [WORD_W-1:0]    out_word_r, out_word_nxt;

  // memory ports
  logic                 sm_we, sm_re;
  logic [IW-1:0]        sm_waddr, sm_raddr;
  slot_entry_t          sm_wentry, sm_rentry;
  logic                 cm_we, cm_re;
  logic [IW-1:0]        cm_slot;
  logic [CIW-1:0]       cm_comp;
  logic [WORD_W-1:0]    cm_wdata, cm_rdata;

  // derived values
  logic [LW-1:0]        lim;
  logic [IW-1:0]        start;
  logic [LW-1:0]        sp_inc, slot_inc;
  logic [IW-1:0]        sp_wrap, slot_wrap;
  logic [IDX_W-1:0]     in_idx;
  logic                 match, comp_ok, cfg_wr;

  ght_slot_store #(
    .DEPTH (MAX_SLOTS),
    .AW    (IW)
  ) u_slot_store (
    .clk    (clk),
    .we     (sm_we),
    .waddr  (sm_waddr),
    .wentry (sm_wentry),
    .re     (sm_re),
    .raddr  (sm_raddr),
    .rentry (sm_rentry)
  );

  ght_comp_store #(
    .SLOTS (MAX_SLOTS),
    .TYPES (COMPONENT_TYPES),
    .SW    (IW),
    .CW    (CIW)
  ) u_comp_store (
    .clk   (clk),
    .we    (cm_we),
    .re    (cm_re),
    .slot  (cm_slot),
    .comp  (cm_comp),
    .wdata (cm_wdata),
    .rdata (cm_rdata)
  );

  // effective limit: entity_limit clamped to 1..MAX_SLOTS
  always_comb begin
    if (limit_r == '0) begin
      lim = LW'(1);
    end else if (32'(limit_r) > 32'(MAX_SLOTS)) begin
      lim = LW'(MAX_SLOTS);
    end else begin
      lim = LW'(limit_r);
    end
  end

  // a stale free pointer at or beyond the limit starts the scan at slot 0
  assign start     = (LW'(fp_r) >= lim) ? '0 : fp_r;
  // next slot with wrap at the limit, for the scan and after a take
  assign sp_inc    = LW'(sp_r) + LW'(1);
  assign sp_wrap   = (sp_inc >= lim) ? '0 : IW'(sp_inc);
  assign slot_inc  = LW'(slot_r) + LW'(1);
  assign slot_wrap = (slot_inc >= lim) ? '0 : IW'(slot_inc);

  assign in_idx  = in_tdata[9:0];
  // handle check against the entry read for sp_r
  assign match   = idx_ok_r && sm_rentry.occ && (sm_rentry.gen == gen_r);
  assign comp_ok = 32'(comp_r) < 32'(COMPONENT_TYPES);

  // configuration write at the access phase
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = limit_r;
    fp_nxt        = fp_r;
    live_nxt      = live_r;
    init_cnt_nxt  = init_cnt_r;
    ph_nxt        = ph_r;
    cclr_busy_nxt = cclr_busy_r;
    cclr_cnt_nxt  = cclr_cnt_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    idx_ok_nxt    = idx_ok_r;
    gen_nxt       = gen_r;
    comp_nxt      = comp_r;
    word_nxt      = word_r;
    sp_nxt        = sp_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    res_sts_nxt   = res_sts_r;
    res_idx_nxt   = res_idx_r;
    res_gen_nxt   = res_gen_r;
    res_word_nxt  = res_word_r;
    out_sts_nxt   = out_sts_r;
    out_idx_nxt   = out_idx_r;
    out_gen_nxt   = out_gen_r;
    out_word_nxt  = out_word_r;

    sm_we     = 1'b0;
    sm_waddr  = sp_r;
    sm_wentry = '0;
    sm_re     = 1'b0;
    sm_raddr  = sp_r;
    cm_we     = 1'b0;
    cm_re     = 1'b0;
    cm_slot   = sp_r;
    cm_comp   = CIW'(comp_r);
    cm_wdata  = word_r;
    in_tready = 1'b0;

    if (cfg_wr && (cfg_paddr[2:2] == REG_ENTITY_LIMIT)) begin
      limit_nxt = cfg_pwdata[LIMIT_W-1:0];
    end

    // component row clear of the slot just taken, one word per cycle
    if (cclr_busy_r) begin
      cm_we    = 1'b1;
      cm_slot  = slot_r;
      cm_comp  = cclr_cnt_r;
      cm_wdata = '0;
      if (cclr_cnt_r == CIW'(COMPONENT_TYPES - 1)) begin
        cclr_busy_nxt = 1'b0;
      end else begin
        cclr_cnt_nxt = cclr_cnt_r + CIW'(1);
      end
    end

    // output register drains independently of the sequencer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        sm_we     = 1'b1;
        sm_waddr  = init_cnt_r;
        sm_wentry = '{occ: 1'b0, gen: GEN_RESET};
        if (init_cnt_r == IW'(MAX_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          init_cnt_nxt = init_cnt_r + IW'(1);
        end
      end

      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt       = op_t'(in_tuser);
          idx_ok_nxt   = 32'(in_idx) < 32'(MAX_SLOTS);
          gen_nxt      = in_tdata[25:10];
          comp_nxt     = in_tdata[28:26];
          word_nxt     = in_tdata[60:29];
          res_sts_nxt  = STS_OK;
          res_idx_nxt  = '0;
          res_gen_nxt  = '0;
          res_word_nxt = '0;
          ph_nxt       = 1'b0;
          cnt_nxt      = lim;
          sp_nxt       = (op_t'(in_tuser) == OP_CREATE) ? start : IW'(in_idx);
          state_nxt    = S_RD;
        end
      end

      S_RD: begin
        sm_re = 1'b1;
        if (op_r == OP_CREATE) begin
          // full check only before the first scan
          if (!ph_r && (live_r >= lim)) begin
            res_sts_nxt = STS_FULL;
            state_nxt   = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end else begin
          state_nxt = S_CHK;
        end
      end

      S_SCAN: begin
        if (!sm_rentry.occ) begin
          if (!ph_r) begin
            slot_nxt    = sp_r;
            res_gen_nxt = sm_rentry.gen;
            state_nxt   = S_TAKE;
          end else begin
            fp_nxt    = sp_r;
            state_nxt = S_FIN;
          end
        end else if (cnt_r == LW'(1)) begin
          if (!ph_r) begin
            res_sts_nxt = STS_FULL;
            state_nxt   = S_RESP;
          end else begin
            // no free slot left: pointer stays at the slot just taken
            fp_nxt    = slot_r;
            state_nxt = S_FIN;
          end
        end else begin
          // read the next slot while this one is checked
          sm_re    = 1'b1;
          sm_raddr = sp_wrap;
          sp_nxt   = sp_wrap;
          cnt_nxt  = cnt_r - LW'(1);
        end
      end

      S_TAKE: begin
        sm_we         = 1'b1;
        sm_waddr      = slot_r;
        sm_wentry     = '{occ: 1'b1, gen: res_gen_r};
        live_nxt      = live_r + LW'(1);
        res_idx_nxt   = IDX_W'(slot_r);
        cclr_busy_nxt = 1'b1;
        cclr_cnt_nxt  = '0;
        ph_nxt        = 1'b1;
        sp_nxt        = slot_wrap;
        cnt_nxt       = lim - LW'(1);
        if (lim == LW'(1)) begin
          fp_nxt    = slot_r;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RD;
        end
      end

      S_FIN: begin
        if (!cclr_busy_r) begin
          state_nxt = S_RESP;
        end
      end

      S_CHK: begin
        state_nxt = S_RESP;
        unique case (op_r)
          OP_FREE: begin
            if (match) begin
              sm_we     = 1'b1;
              sm_waddr  = sp_r;
              sm_wentry = '{occ: 1'b0, gen: sm_rentry.gen + GEN_W'(1)};
              // freeing on a full table points the next create here
              if (live_r >= lim) begin
                fp_nxt = sp_r;
              end
              if (live_r != '0) begin
                live_nxt = live_r - LW'(1);
              end
            end else begin
              res_sts_nxt = STS_STALE;
            end
          end
          OP_SET: begin
            if (match && comp_ok) begin
              cm_we = 1'b1;
            end else begin
              res_sts_nxt = STS_STALE;
            end
          end
          OP_GET: begin
            if (match && comp_ok) begin
              cm_re     = 1'b1;
              state_nxt = S_GETW;
            end else begin
              res_sts_nxt = STS_STALE;
            end
          end
          OP_CREATE: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      S_GETW: begin
        res_word_nxt = cm_rdata;
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = res_sts_r;
          out_idx_nxt   = res_idx_r;
          out_gen_nxt   = res_gen_r;
          out_word_nxt  = res_word_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      limit_r     <= LIMIT_RESET;
      fp_r        <= '0;
      live_r      <= '0;
      init_cnt_r  <= '0;
      ph_r        <= 1'b0;
      cclr_busy_r <= 1'b0;
      cclr_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      fp_r        <= fp_nxt;
      live_r      <= live_nxt;
      init_cnt_r  <= init_cnt_nxt;
      ph_r        <= ph_nxt;
      cclr_busy_r <= cclr_busy_nxt;
      cclr_cnt_r  <= cclr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_ok_r   <= idx_ok_nxt;
    gen_r      <= gen_nxt;
    comp_r     <= comp_nxt;
    word_r     <= word_nxt;
    sp_r       <= sp_nxt;
    cnt_r      <= cnt_nxt;
    slot_r     <= slot_nxt;
    res_sts_r  <= res_sts_nxt;
    res_idx_r  <= res_idx_nxt;
    res_gen_r  <= res_gen_nxt;
    res_word_r <= res_word_nxt;
    out_sts_r  <= out_sts_nxt;
    out_idx_r  <= out_idx_nxt;
    out_gen_r  <= out_gen_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sts_r;
  assign out_tdata  = {6'b0, out_word_r, out_gen_r, out_idx_r};

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2:2] == REG_ENTITY_LIMIT) ? CFG_DATA_W'(limit_r) : '0;

  // the slot taken by create was seen unoccupied by the scan
  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAKE) |-> !$past(sm_rentry.occ))
    else $error("create took an occupied slot");

  // live count never passes the slot count
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LW'(MAX_SLOTS))
    else $error("live count beyond slot count");

  // row clear only runs inside a create, before its result
  a_clear_in_create: assert property (@(posedge clk) disable iff (!rst_n)
    cclr_busy_r |-> (op_r == OP_CREATE &&
                     (state_r == S_RD || state_r == S_SCAN || state_r == S_FIN)))
    else $error("component clear outside create");

  // a successful create leaves at least one live slot
  a_create_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && op_r == OP_CREATE && res_sts_r == STS_OK) |-> (live_r != '0))
    else $error("create ok with no live slot");

endmodule
